/* hw/rtl/socks5_client_handshake_defines.svh */
// Assertion macros for the SOCKS5 client handshake RTL.
// Included by the top level; expects clk and rst_n in scope.
`ifndef SOCKS5_CLIENT_HANDSHAKE_DEFINES_SVH
`define SOCKS5_CLIENT_HANDSHAKE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define S5_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define S5_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/s5_pkg.sv */
// Shared constants for the SOCKS5 client handshake: item kinds, phases,
// status codes, protocol bytes and credential store geometry. No dependencies.
package s5_pkg;

  localparam int CRED_DEPTH   = 512;
  localparam int CRED_ADDR_W  = $clog2(CRED_DEPTH);
  localparam int MAX_CRED_LEN = 255;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_RX    = 2'd2;
  localparam logic [1:0] KIND_PULL  = 2'd3;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_GREET_TX = 4'd1;
  localparam logic [3:0] PH_GREET_RX = 4'd2;
  localparam logic [3:0] PH_AUTH_TX  = 4'd3;
  localparam logic [3:0] PH_AUTH_RX  = 4'd4;
  localparam logic [3:0] PH_CONN_TX  = 4'd5;
  localparam logic [3:0] PH_REPLY_RX = 4'd6;
  localparam logic [3:0] PH_DOM_LEN  = 4'd7;
  localparam logic [3:0] PH_ADDR_RX  = 4'd8;
  localparam logic [3:0] PH_DONE     = 4'd9;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_BUSY      = 4'd1;
  localparam logic [3:0] ST_CONNECTED = 4'd2;
  localparam logic [3:0] ST_NOT_SOCKS = 4'd3;
  localparam logic [3:0] ST_NO_USER   = 4'd4;
  localparam logic [3:0] ST_AUTH_REJ  = 4'd5;
  localparam logic [3:0] ST_METHOD    = 4'd6;
  localparam logic [3:0] ST_BAD_DEST  = 4'd7;
  localparam logic [3:0] ST_BAD_REPLY = 4'd8;
  localparam logic [3:0] ST_REFUSED   = 4'd9;
  localparam logic [3:0] ST_BAD_ATYP  = 4'd10;

  localparam logic [1:0] REG_USER_LEN  = 2'd0;
  localparam logic [1:0] REG_PASS_LEN  = 2'd1;
  localparam logic [1:0] REG_DEST_ADDR = 2'd2;
  localparam logic [1:0] REG_DEST_PORT = 2'd3;

  localparam logic [7:0] SOCKS_VER      = 8'h05;
  localparam logic [7:0] AUTH_VER       = 8'h01;
  localparam logic [7:0] METHOD_NONE    = 8'h00;
  localparam logic [7:0] METHOD_USERPW  = 8'h02;
  localparam logic [7:0] CMD_CONNECT    = 8'h01;
  localparam logic [7:0] ATYP_IPV4      = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
  localparam logic [7:0] ATYP_IPV6      = 8'h04;
  localparam logic [7:0] REPLY_OK       = 8'h00;
  localparam logic [31:0] ADDR_BCAST    = 32'hFFFF_FFFF;

  // Bytes still to drain after the address type: address plus port.
  localparam logic [8:0] DRAIN_IPV4 = 9'd6;
  localparam logic [8:0] DRAIN_IPV6 = 9'd18;

  localparam logic [9:0] CONN_LEN = 10'd10;

endpackage

/* hw/rtl/s5_ifs.sv */
// Valid/ready channel interfaces for the SOCKS5 client handshake:
// item input, result output and register write. No dependencies.
interface s5_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [8:0] cred_index;
  modport source (output valid, kind, data_byte, cred_index, input ready);
  modport sink   (input valid, kind, data_byte, cred_index, output ready);
endinterface

interface s5_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic [3:0] status;
  logic [7:0] reply_code;
  modport source (output valid, tx_valid, tx_byte, tx_last, status, reply_code, input ready);
  modport sink   (input valid, tx_valid, tx_byte, tx_last, status, reply_code, output ready);
endinterface

interface s5_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/s5_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is enabled. No dependencies.
module s5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/socks5_client_handshake.sv */
// Top level of the SOCKS5 client handshake (IPv4 CONNECT).
// Depends on s5_pkg, s5_ifs, s5_ram and socks5_client_handshake_defines.svh.

// One item is accepted every clock cycle while the result side keeps up, and
// each item's result beat passes first through stage A, alongside the
// registered read of the credential store, which supplies username and
// password bytes during the authentication message, and then through the output
// register. Protocol state lives in flops and is updated when an item is
// accepted. The credential store needs no clearing after reset; entries are
// only defined once loaded. Register writes are accepted on every cycle.
`include "socks5_client_handshake_defines.svh"

module socks5_client_handshake
  import s5_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  s5_in_if.sink      in_ch,
  s5_out_if.source   out_ch,
  s5_cfg_if.sink     cfg_ch
);

  // Configuration registers.
  logic [7:0]  user_len_r;
  logic [7:0]  pass_len_r;
  logic [31:0] dest_addr_r;
  logic [15:0] dest_port_r;

  // Protocol state.
  logic [3:0] phase_r, phase_nxt;
  logic [9:0] cnt_r, cnt_nxt;
  logic [8:0] left_r, left_nxt;
  logic [3:0] outcome_r, outcome_nxt;
  logic [7:0] refusal_r, refusal_nxt;

  // Stage A: result fields waiting on the store read.
  logic       a_valid_r;
  logic       a_tx_valid_r, a_tx_valid_nxt;
  logic [7:0] a_tx_byte_r, a_tx_byte_nxt;
  logic       a_use_ram_r, a_use_ram_nxt;
  logic       a_tx_last_r, a_tx_last_nxt;
  logic [3:0] a_status_r;
  logic [7:0] a_reply_r;

  // Output register.
  logic       out_valid_r;
  logic       out_tx_valid_r;
  logic [7:0] out_tx_byte_r;
  logic       out_tx_last_r;
  logic [3:0] out_status_r;
  logic [7:0] out_reply_r;

  logic accept;
  logic advance;
  logic [CRED_ADDR_W-1:0] rd_addr;
  logic [7:0] ram_rdata;

  assign advance      = a_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !a_valid_r || advance;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_len_r  <= '0;
      pass_len_r  <= '0;
      dest_addr_r <= '0;
      dest_port_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_USER_LEN:  user_len_r  <= cfg_ch.data[7:0];
        REG_PASS_LEN:  pass_len_r  <= cfg_ch.data[7:0];
        REG_DEST_ADDR: dest_addr_r <= cfg_ch.data;
        REG_DEST_PORT: dest_port_r <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  s5_ram #(
    .WIDTH (8),
    .DEPTH (CRED_DEPTH)
  ) u_cred (
    .clk   (clk),
    .we    (accept && (in_ch.kind == KIND_LOAD)),
    .waddr (in_ch.cred_index),
    .wdata (in_ch.data_byte),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    logic [9:0] ul10;
    logic [9:0] pl10;
    logic [9:0] len;
    logic [9:0] cnt_inc;
    logic [9:0] pw_off;
    logic [7:0] b;
    logic       bad_len;

    ul10    = {2'b00, user_len_r};
    pl10    = {2'b00, pass_len_r};
    cnt_inc = cnt_r + 10'd1;
    pw_off  = cnt_r - 10'd3 - ul10;
    b       = in_ch.data_byte;
    bad_len = ({1'b0, user_len_r} > 9'(MAX_CRED_LEN))
           || ({1'b0, pass_len_r} > 9'(MAX_CRED_LEN));

    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    left_nxt       = left_r;
    outcome_nxt    = outcome_r;
    refusal_nxt    = refusal_r;
    a_tx_valid_nxt = 1'b0;
    a_tx_byte_nxt  = '0;
    a_use_ram_nxt  = 1'b0;
    a_tx_last_nxt  = 1'b0;
    rd_addr        = {1'b0, cnt_r[7:0] - 8'd2};

    case (phase_r)
      PH_GREET_TX: len = (user_len_r != 8'd0) ? 10'd4 : 10'd3;
      PH_AUTH_TX:  len = 10'd3 + ul10 + pl10;
      default:     len = CONN_LEN;
    endcase

    case (in_ch.kind)
      KIND_START: begin
        outcome_nxt = ST_BUSY;
        refusal_nxt = '0;
        left_nxt    = '0;
        phase_nxt   = PH_GREET_TX;
        cnt_nxt     = '0;
      end
      KIND_LOAD: ;
      KIND_RX: begin
        case (phase_r)
          PH_GREET_RX: begin
            if (cnt_r == 10'd0) begin
              if (b != SOCKS_VER) begin
                outcome_nxt = ST_NOT_SOCKS;
                phase_nxt   = PH_DONE;
              end else begin
                cnt_nxt = 10'd1;
              end
            end else if (b == METHOD_USERPW) begin
              if (user_len_r == 8'd0) begin
                outcome_nxt = ST_NO_USER;
                phase_nxt   = PH_DONE;
              end else if (bad_len) begin
                outcome_nxt = ST_AUTH_REJ;
                phase_nxt   = PH_DONE;
              end else begin
                phase_nxt = PH_AUTH_TX;
                cnt_nxt   = '0;
              end
            end else if (b != METHOD_NONE) begin
              outcome_nxt = ST_METHOD;
              phase_nxt   = PH_DONE;
            end else if (dest_addr_r == ADDR_BCAST) begin
              outcome_nxt = ST_BAD_DEST;
              phase_nxt   = PH_DONE;
            end else begin
              phase_nxt = PH_CONN_TX;
              cnt_nxt   = '0;
            end
          end
          PH_AUTH_RX: begin
            // The version byte of the auth reply is not checked.
            if (cnt_r == 10'd0) begin
              cnt_nxt = 10'd1;
            end else if (b != REPLY_OK) begin
              outcome_nxt = ST_AUTH_REJ;
              phase_nxt   = PH_DONE;
            end else if (dest_addr_r == ADDR_BCAST) begin
              outcome_nxt = ST_BAD_DEST;
              phase_nxt   = PH_DONE;
            end else begin
              phase_nxt = PH_CONN_TX;
              cnt_nxt   = '0;
            end
          end
          PH_REPLY_RX: begin
            if (cnt_r == 10'd0) begin
              if (b != SOCKS_VER) begin
                outcome_nxt = ST_BAD_REPLY;
                phase_nxt   = PH_DONE;
              end else begin
                cnt_nxt = 10'd1;
              end
            end else if (cnt_r == 10'd1) begin
              if (b != REPLY_OK) begin
                refusal_nxt = b;
                outcome_nxt = ST_REFUSED;
                phase_nxt   = PH_DONE;
              end else begin
                cnt_nxt = 10'd2;
              end
            end else if (cnt_r == 10'd2) begin
              cnt_nxt = 10'd3;
            end else if (b == ATYP_IPV4) begin
              left_nxt  = DRAIN_IPV4;
              phase_nxt = PH_ADDR_RX;
              cnt_nxt   = '0;
            end else if (b == ATYP_IPV6) begin
              left_nxt  = DRAIN_IPV6;
              phase_nxt = PH_ADDR_RX;
              cnt_nxt   = '0;
            end else if (b == ATYP_DOMAIN) begin
              phase_nxt = PH_DOM_LEN;
              cnt_nxt   = '0;
            end else begin
              outcome_nxt = ST_BAD_ATYP;
              phase_nxt   = PH_DONE;
            end
          end
          PH_DOM_LEN: begin
            left_nxt  = {1'b0, b} + 9'd2;
            phase_nxt = PH_ADDR_RX;
            cnt_nxt   = '0;
          end
          PH_ADDR_RX: begin
            if (left_r != 9'd0) begin
              left_nxt = left_r - 9'd1;
            end
            if (left_r <= 9'd1) begin
              outcome_nxt = ST_CONNECTED;
              phase_nxt   = PH_DONE;
            end
          end
          default: ;
        endcase
      end
      default: begin
        if (phase_r == PH_GREET_TX || phase_r == PH_AUTH_TX || phase_r == PH_CONN_TX) begin
          a_tx_valid_nxt = 1'b1;
          case (phase_r)
            PH_GREET_TX: begin
              case (cnt_r)
                10'd0:   a_tx_byte_nxt = SOCKS_VER;
                10'd1:   a_tx_byte_nxt = (user_len_r != 8'd0) ? 8'd2 : 8'd1;
                10'd2:   a_tx_byte_nxt = METHOD_NONE;
                10'd3:   a_tx_byte_nxt = (user_len_r != 8'd0) ? METHOD_USERPW : 8'd0;
                default: a_tx_byte_nxt = '0;
              endcase
            end
            PH_AUTH_TX: begin
              // Credential bytes come from the registered read of the store.
              if (cnt_r == 10'd0) begin
                a_tx_byte_nxt = AUTH_VER;
              end else if (cnt_r == 10'd1) begin
                a_tx_byte_nxt = user_len_r;
              end else if (cnt_r < ul10 + 10'd2) begin
                a_use_ram_nxt = 1'b1;
              end else if (cnt_r == ul10 + 10'd2) begin
                a_tx_byte_nxt = pass_len_r;
              end else if (cnt_r < ul10 + pl10 + 10'd3) begin
                a_use_ram_nxt = 1'b1;
                rd_addr       = {1'b1, pw_off[7:0]};
              end
            end
            default: begin
              case (cnt_r)
                10'd0:   a_tx_byte_nxt = SOCKS_VER;
                10'd1:   a_tx_byte_nxt = CMD_CONNECT;
                10'd2:   a_tx_byte_nxt = 8'h00;
                10'd3:   a_tx_byte_nxt = ATYP_IPV4;
                10'd4:   a_tx_byte_nxt = dest_addr_r[31:24];
                10'd5:   a_tx_byte_nxt = dest_addr_r[23:16];
                10'd6:   a_tx_byte_nxt = dest_addr_r[15:8];
                10'd7:   a_tx_byte_nxt = dest_addr_r[7:0];
                10'd8:   a_tx_byte_nxt = dest_port_r[15:8];
                10'd9:   a_tx_byte_nxt = dest_port_r[7:0];
                default: a_tx_byte_nxt = '0;
              endcase
            end
          endcase
          if (cnt_inc >= len) begin
            a_tx_last_nxt = 1'b1;
            cnt_nxt       = '0;
            case (phase_r)
              PH_GREET_TX: phase_nxt = PH_GREET_RX;
              PH_AUTH_TX:  phase_nxt = PH_AUTH_RX;
              default:     phase_nxt = PH_REPLY_RX;
            endcase
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cnt_r     <= '0;
      left_r    <= '0;
      outcome_r <= ST_IDLE;
      refusal_r <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      left_r    <= left_nxt;
      outcome_r <= outcome_nxt;
      refusal_r <= refusal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (accept) begin
      a_valid_r <= 1'b1;
    end else if (advance) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_tx_valid_r <= a_tx_valid_nxt;
      a_tx_byte_r  <= a_tx_byte_nxt;
      a_use_ram_r  <= a_use_ram_nxt;
      a_tx_last_r  <= a_tx_last_nxt;
      a_status_r   <= outcome_nxt;
      a_reply_r    <= (outcome_nxt == ST_REFUSED) ? refusal_nxt : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tx_valid_r <= a_tx_valid_r;
      out_tx_byte_r  <= a_use_ram_r ? ram_rdata : a_tx_byte_r;
      out_tx_last_r  <= a_tx_last_r;
      out_status_r   <= a_status_r;
      out_reply_r    <= a_reply_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.tx_valid   = out_tx_valid_r;
  assign out_ch.tx_byte    = out_tx_byte_r;
  assign out_ch.tx_last    = out_tx_last_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.reply_code = out_reply_r;

  `S5_ASSERT_NOW(a_idle_outcome, phase_r == PH_IDLE, outcome_r == ST_IDLE, "idle phase with an outcome set")
  `S5_ASSERT_NOW(a_greet_cnt, phase_r == PH_GREET_RX, cnt_r <= 10'd1, "greeting reply counter out of range")
  `S5_ASSERT_NEXT(a_stage_hold, a_valid_r && !advance, a_valid_r && $stable(a_status_r), "stalled stage A lost its item")
  `S5_ASSERT_NOW(a_reply_only_refused, a_valid_r && a_reply_r != 8'd0, a_status_r == ST_REFUSED, "reply code without refusal")

endmodule
